/* rtl/core/modinv_pkg.sv */
package modinv_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE
    } t_state;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;      // take a new item, seed the Euclid pairs
        logic div_init;  // clear the divider for a new round
        logic div_step;  // one quotient bit
        logic update;    // rotate the remainder and coefficient pairs
        logic finish;    // form the result
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic nr_zero;   // newer remainder is zero, Euclid is done
    } t_sts;

endpackage

/* rtl/core/modinv_ctrl.sv */
module modinv_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  modinv_pkg::t_sts  i_sts,
    output modinv_pkg::t_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import modinv_pkg::*;

    localparam int CW = $clog2(WIDTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_valid;
    t_cmd            cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= cmd.finish;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.nr_zero) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    cmd.div_init = 1'b1;
                    n_cnt        = '0;
                    n_state      = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                n_state    = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

/* rtl/core/modinv_dp.sv */
module modinv_dp #(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  modinv_pkg::t_cmd  i_cmd,
    input  logic [WIDTH-1:0]  i_modulus,
    input  logic [WIDTH-1:0]  i_value,
    output modinv_pkg::t_sts  o_sts,
    output logic [WIDTH-1:0]  o_inverse,
    output logic              o_found
);
    import modinv_pkg::*;

    // Euclid pairs: remainders, coefficient magnitudes, sign of older one
    logic [WIDTH-1:0] r_r, r_nr, r_tm, r_ntm;
    logic             r_tneg;
    // Restoring divider: partial remainder, dividend shifter, q*ntm accumulator
    logic [WIDTH-1:0] r_rem, r_dvd, r_acc;
    logic [WIDTH-1:0] r_inv;
    logic             r_found;

    logic [WIDTH:0]   shifted, diff;
    logic             qbit;
    logic [WIDTH-1:0] n_rem, n_acc, lifted, n_inv;
    logic             n_found;

    always_comb begin
        shifted = {r_rem, r_dvd[WIDTH-1]};
        diff    = shifted - {1'b0, r_nr};
        qbit    = ~diff[WIDTH];
        n_rem   = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        // Horner form of q*ntm, one quotient bit at a time, MSB first
        n_acc   = {r_acc[WIDTH-2:0], 1'b0} + (qbit ? r_ntm : '0);

        lifted  = (r_tneg && (r_tm != '0)) ? (i_modulus - r_tm) : r_tm;
        n_found = (r_r == WIDTH'(1));
        n_inv   = n_found ? lifted : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r    <= i_modulus;
            r_nr   <= i_value;
            r_tm   <= '0;
            r_ntm  <= WIDTH'(1);
            r_tneg <= 1'b1;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dvd <= r_r;
            r_acc <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_acc <= n_acc;
        end
        if (i_cmd.update) begin
            r_r    <= r_nr;
            r_nr   <= r_rem;
            r_tm   <= r_ntm;
            r_ntm  <= r_acc + r_tm;
            r_tneg <= ~r_tneg;
        end
        if (i_cmd.finish) begin
            r_inv   <= n_inv;
            r_found <= n_found;
        end
    end

    assign o_sts.nr_zero = (r_nr == '0);
    assign o_inverse     = r_inv;
    assign o_found       = r_found;

endmodule

/* rtl/core/modular_inverse_u32.sv */
// Modular inverse by the extended Euclidean algorithm.
//
// Config: APB-style slave with one register, the modulus, at byte address 0
//   (reset value 65537). pready is tied high; writes land on the access
//   cycle. Write the modulus only while busy is low.
// Input: an item is taken on the rising edge where start is high and busy
//   is low; i_value is sampled on that edge.
// Output: o_inverse and o_found appear for one cycle with o_valid high.
//   The receiver cannot stall; the result is simply presented once.
//   o_found low means gcd(value, modulus) != 1 and o_inverse is then 0.
// Timing: the item is worked on alone. Each Euclid round is a restoring
//   division (one quotient bit per cycle, with q*ntm built alongside)
//   plus a check state and an update state. o_valid is registered and
//   rises once the check finds the newer remainder zero; there are at most
//   about 46 rounds for 32-bit operands. busy drops in the cycle o_valid is
//   shown, so the next item can be started right then.
// Reset: synchronous, active low; returns the sequencer to idle, drops
//   o_valid and reloads the modulus with 65537.
module modular_inverse_u32 #(
    parameter int WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [((WIDTH > 32) ? 4 : 3)-1:0]    paddr,
    input  logic [((WIDTH > 32) ? 64 : 32)-1:0]  pwdata,
    output logic [((WIDTH > 32) ? 64 : 32)-1:0]  prdata,
    output logic                                 pready,
    // item in
    input  logic                                 start,
    output logic                                 busy,
    input  logic [WIDTH-1:0]                     i_value,
    // result out
    output logic                                 o_valid,
    output logic [WIDTH-1:0]                     o_inverse,
    output logic                                 o_found
);
    import modinv_pkg::*;

    localparam int AW  = (WIDTH > 32) ? 4 : 3;
    localparam int PW  = (WIDTH > 32) ? 64 : 32;
    localparam int OFS = (WIDTH > 32) ? 3 : 2;   // byte offset bits per register

    logic [WIDTH-1:0] r_modulus;
    logic             addr_hit;
    t_cmd             cmd;
    t_sts             sts;

    // Only register 0 exists; anything above it is ignored on write, reads 0
    assign addr_hit = (paddr[AW-1:OFS] == '0);
    assign pready   = 1'b1;
    assign prdata   = addr_hit ? PW'(r_modulus) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(65537);
        end else if (psel && penable && pwrite && addr_hit) begin
            r_modulus <= pwdata[WIDTH-1:0];
        end
    end

    // Sequencer: owns the quotient bit counter and the result strobe
    modinv_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Euclid registers, shared divider and result registers
    modinv_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_modulus (r_modulus),
        .i_value   (i_value),
        .o_sts     (sts),
        .o_inverse (o_inverse),
        .o_found   (o_found)
    );

endmodule

/* tb/sv/modinv_checker.sv */
module modinv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_value,
    input  logic        o_valid,
    input  logic [31:0] o_inverse,
    input  logic        o_found,
    output int          n_errors,
    output int          n_pending,
    output int          n_checked,
    output int          n_found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  ADDR_MODULUS  = 3'd0;
    localparam logic [31:0] MODULUS_RESET = 32'd65537;

    typedef struct packed {
        logic [31:0] inverse;
        logic        found;
    } inv_t;

    logic [31:0] modulus_q = MODULUS_RESET;
    inv_t        inverses_q[$];

    initial begin
        n_errors  = 0;
        n_pending = 0;
        n_checked = 0;
        n_found   = 0;
    end

    // Extended Euclid with the coefficient as magnitude plus alternating sign.
    function automatic inv_t euclid_inverse(input logic [31:0] a, input logic [31:0] m);
        logic [63:0] r_old, r_new, t_old, t_new, quo, rem, t_next;
        logic        old_neg;
        inv_t        res;
        r_old   = 64'(m);
        r_new   = 64'(a);
        t_old   = 64'd0;
        t_new   = 64'd1;
        old_neg = 1'b1;
        while (r_new != 0) begin
            quo     = r_old / r_new;
            rem     = r_old - quo * r_new;
            t_next  = t_old + quo * t_new;
            r_old   = r_new;
            r_new   = rem;
            t_old   = t_new;
            t_new   = t_next;
            old_neg = !old_neg;
        end
        if (r_old != 64'd1) begin
            res.inverse = '0;
            res.found   = 1'b0;
        end else if (old_neg && t_old != 0) begin
            res.inverse = 32'(64'(m) - t_old);
            res.found   = 1'b1;
        end else begin
            res.inverse = t_old[31:0];
            res.found   = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        inv_t want;
        if (!i_rst_n) begin
            modulus_q = MODULUS_RESET;
            inverses_q.delete();
        end else begin
            // result first: an item may be accepted on the edge that ends the last one
            if (o_valid) begin
                if (inverses_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result inverse=%h found=%b",
                             $time, o_inverse, o_found);
                end else begin
                    want = inverses_q.pop_front();
                    n_checked++;
                    if (want.found) n_found++;
                    if (o_inverse !== want.inverse) begin
                        n_errors++;
                        $display("%0t: inverse mismatch expected %h actual %h",
                                 $time, want.inverse, o_inverse);
                    end
                    if (o_found !== want.found) begin
                        n_errors++;
                        $display("%0t: found mismatch expected %b actual %b",
                                 $time, want.found, o_found);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS)
                modulus_q = pwdata;
            if (start && !busy)
                inverses_q.push_back(euclid_inverse(i_value, modulus_q));
        end
        n_pending = inverses_q.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MODULUS = 3'd0;
    localparam int         N_PHASES     = 8;
    localparam int         PHASE_ITEMS  = 50;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    // config port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    // item channel
    logic        start   = 1'b0;
    logic        busy;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic [31:0] o_inverse;
    logic        o_found;

    int n_errors, n_pending, n_checked, n_found;
    int idle_pct   = 0;   // chance per cycle that the sender holds back
    int n_items    = 0;
    int n_settings = 0;

    always #5 i_clk = ~i_clk;

    modular_inverse_u32 DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .o_inverse (o_inverse),
        .o_found   (o_found)
    );

    modinv_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .o_inverse (o_inverse),
        .o_found   (o_found),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_checked (n_checked),
        .n_found   (n_found)
    );

    // Drop start and wait until every item in flight has produced its result.
    // Each item gives exactly one result, so an empty queue means idle.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (n_pending != 0 || busy) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; lands when pready is seen high.
    task automatic write_modulus(input logic [31:0] m);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODULUS;
        pwdata  <= m;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    // Present one item and hold it until accepted. With idling on, the sender
    // sometimes waits for the block to go idle and then holds back at random,
    // so gaps also land while the block sits idle.
    task automatic send_value(input logic [31:0] v);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(negedge i_clk); while (busy || $urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        n_items++;
    endtask

    // Operand mix: mostly random, some reduced, some sharing a factor with
    // the modulus, some at the edges around it.
    function automatic logic [31:0] next_operand(input logic [31:0] m);
        int unsigned roll;
        logic [31:0] k;
        roll = $urandom_range(99);
        k    = 32'($urandom_range(1, 5000));
        if (roll < 55)
            return $urandom();
        if (roll < 75)
            return (m == 0) ? $urandom() : $urandom() % m;
        if (roll < 88) begin
            case ($urandom_range(3))
                0:       return 32'd2 * k;
                1:       return 32'd3 * k;
                2:       return m * k;
                default: return m - 32'($urandom_range(0, 3));
            endcase
        end
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return m - 32'd1;
            3:       return m;
            4:       return m + 32'd1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial begin : stim
        logic [31:0] phase_mod[N_PHASES];

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset modulus 65537 first
        send_value(32'd0);              // gcd is the modulus -> none
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd65536);          // modulus - 1
        send_value(32'd65537);          // equals modulus
        send_value(32'd65538);          // above modulus, not reduced first
        send_value(32'hFFFF_FFFF);
        send_value(32'd3);
        settle();

        // modulus one: zero and nonzero values both give 0/found
        write_modulus(32'd1);
        send_value(32'd0);
        send_value(32'd5);
        send_value(32'hFFFF_FFFF);
        settle();

        // modulus zero: only value one has an inverse
        write_modulus(32'd0);
        send_value(32'd1);
        send_value(32'd0);
        send_value(32'd7);
        settle();

        // largest modulus, divisible by 3
        write_modulus(32'hFFFF_FFFF);
        send_value(32'hFFFF_FFFE);
        send_value(32'd3);
        send_value(32'd2);
        settle();

        // consecutive Fibonacci numbers: longest Euclid chain at 32 bits
        write_modulus(32'd2971215073);
        send_value(32'd1836311903);
        send_value(32'd2971215072);
        send_value(32'hFFFF_FFFF);
        settle();

        write_modulus(32'd2);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        settle();

        // random phases, one modulus each; idling cycles through off/50/18
        phase_mod[0] = $urandom() | 32'h8000_0001;
        phase_mod[1] = 32'hFFFF_FFFF;
        phase_mod[2] = 32'd2971215073;
        phase_mod[3] = 32'($urandom_range(2, 1000));
        phase_mod[4] = 32'd4294967291;          // largest 32-bit prime
        phase_mod[5] = ($urandom() & ~32'd1) | 32'h8000_0000;
        phase_mod[6] = 32'($urandom_range(1000, 65535));
        phase_mod[7] = 32'd1;

        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 50;
                default: idle_pct = 18;
            endcase
            write_modulus(phase_mod[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(next_operand(phase_mod[p]));
            settle();
        end

        // nothing can still be in flight; a short drain for stray strobes
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        $display("covered %0d items over %0d modulus writes incl. 0, 1 and 2^32-1",
                 n_items, n_settings);
        $display("%0d results checked, %0d with an inverse, %0d without",
                 n_checked, n_found, n_checked - n_found);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // The timeout allows several times the worst case over all items.
    initial begin : watchdog
        #30_000_000;
        $display("timeout after %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* modular_inverse_u32.f */
rtl/core/modinv_pkg.sv
rtl/core/modinv_ctrl.sv
rtl/core/modinv_dp.sv
rtl/core/modular_inverse_u32.sv
tb/sv/modinv_checker.sv
tb/sv/tb.sv
